### rtl/recursive_lock_with_wait_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// Recursive lock unit assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_LOCK_WITH_WAIT_QUEUE_UNIT_MACROS_SVH
`define RECURSIVE_LOCK_WITH_WAIT_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTH
`define RLWQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RLWQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RLWQ_ASSERT(lbl, prop, msg)
`define RLWQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/rlwq_pkg.sv
// ----------------------------------------------------------------------------
// Recursive lock package
// Sizes, request kinds and result status codes of the recursive lock unit.
// ----------------------------------------------------------------------------
package rlwq_pkg;

  localparam int THREADS    = 16;
  localparam int COUNT_BITS = 8;
  localparam int TidW       = 4;
  localparam int HoldW      = 8;
  localparam int PtrW       = $clog2(THREADS);
  localparam int FillW      = $clog2(THREADS + 1);

  typedef enum logic {
    REQ_ACQUIRE = 1'b0,
    REQ_RELEASE = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_GRANT    = 3'd0,
    ST_NEST     = 3'd1,
    ST_BLOCKED  = 3'd2,
    ST_NEST_REL = 3'd3,
    ST_FREED    = 3'd4,
    ST_ERROR    = 3'd5
  } status_t;

endpackage

### rtl/rlwq_req_if.sv
// ----------------------------------------------------------------------------
// Recursive lock request channel
// Valid/ready channel carrying one acquire or release request per beat.
// ----------------------------------------------------------------------------
interface rlwq_req_if;
  logic                          valid;
  logic                          ready;
  rlwq_pkg::req_t                req_type;
  logic [rlwq_pkg::TidW-1:0]     thread_id;

  modport source (output valid, req_type, thread_id, input ready);
  modport sink   (input valid, req_type, thread_id, output ready);
endinterface

### rtl/rlwq_res_if.sv
// ----------------------------------------------------------------------------
// Recursive lock result channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface rlwq_res_if;
  logic                          valid;
  logic                          ready;
  rlwq_pkg::status_t             status;
  logic                          woken_valid;
  logic [rlwq_pkg::TidW-1:0]     woken_thread;
  logic [rlwq_pkg::HoldW-1:0]    hold_depth;

  modport source (output valid, status, woken_valid, woken_thread, hold_depth,
                  input ready);
  modport sink   (input valid, status, woken_valid, woken_thread, hold_depth,
                  output ready);
endinterface

### rtl/recursive_lock_with_wait_queue_unit.sv
// ----------------------------------------------------------------------------
// Recursive lock with wait queue
// Holder, nesting count and a FIFO of blocked threads, one request per beat.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel: an acquire or a release with a thread
// id. Each request beat produces exactly one result beat on the res channel
// with a status, the thread woken by a final release, if any, and the
// nesting depth after the request.
// The state update and the result are computed in the cycle the request is
// accepted and both are registered at that edge, so a result appears in the
// cycle after its request. One request is taken every cycle unless the
// receiver stalls; the single result register sets that figure, and the
// next request sees the state left by the previous one without a bubble.
// The request side is ready while the result register is empty or is being
// drained in the same cycle. When the receiver stalls, the pending result
// holds and the request side stops after that one result.
// Synchronous reset frees the lock, empties the wait queue and drops any
// pending result; no request is taken while reset is high.
// ----------------------------------------------------------------------------
`include "recursive_lock_with_wait_queue_unit_macros.svh"

module recursive_lock_with_wait_queue_unit (
  input  logic       clk,
  input  logic       rst,
  rlwq_req_if.sink   req,
  rlwq_res_if.source res
);

  logic                              lock_free;
  logic [rlwq_pkg::TidW-1:0]         holder_id;
  logic [rlwq_pkg::COUNT_BITS-1:0]   nest_count;
  logic [rlwq_pkg::TidW-1:0]         waiter_fifo [rlwq_pkg::THREADS];
  logic [rlwq_pkg::PtrW-1:0]         fifo_head;
  logic [rlwq_pkg::PtrW-1:0]         fifo_tail;
  logic [rlwq_pkg::FillW-1:0]        fifo_fill;
  logic [rlwq_pkg::THREADS-1:0]      waiting_mask;

  logic                              out_valid;
  rlwq_pkg::status_t                 out_status;
  logic                              out_woken_valid;
  logic [rlwq_pkg::TidW-1:0]         out_woken_thread;
  logic [rlwq_pkg::HoldW-1:0]        out_hold_depth;

  logic                              lock_free_next;
  logic [rlwq_pkg::TidW-1:0]         holder_id_next;
  logic [rlwq_pkg::COUNT_BITS-1:0]   nest_count_next;
  logic [rlwq_pkg::PtrW-1:0]         fifo_head_next;
  logic [rlwq_pkg::PtrW-1:0]         fifo_tail_next;
  logic [rlwq_pkg::FillW-1:0]        fifo_fill_next;
  logic [rlwq_pkg::THREADS-1:0]      waiting_mask_next;
  rlwq_pkg::status_t                 status_next;
  logic                              woken_valid_next;
  logic [rlwq_pkg::TidW-1:0]         woken_thread_next;
  logic                              fifo_push;

  logic                              acc;
  logic                              tid_ok;
  logic [rlwq_pkg::PtrW-1:0]         tid_idx;
  logic [rlwq_pkg::TidW-1:0]         head_tid;
  logic [rlwq_pkg::COUNT_BITS-1:0]   count_max;

  assign req.ready = !rst && (!out_valid || res.ready);
  assign acc       = req.valid && req.ready;

  assign tid_ok    = (32'(req.thread_id) < rlwq_pkg::THREADS);
  assign tid_idx   = rlwq_pkg::PtrW'(req.thread_id);
  assign head_tid  = waiter_fifo[fifo_head];
  assign count_max = {rlwq_pkg::COUNT_BITS{1'b1}};

  function automatic logic [rlwq_pkg::PtrW-1:0] next_slot(
    input logic [rlwq_pkg::PtrW-1:0] p
  );
    logic [rlwq_pkg::PtrW-1:0] n;
    if (32'(p) == rlwq_pkg::THREADS - 1) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  always_comb begin
    lock_free_next    = lock_free;
    holder_id_next    = holder_id;
    nest_count_next   = nest_count;
    fifo_head_next    = fifo_head;
    fifo_tail_next    = fifo_tail;
    fifo_fill_next    = fifo_fill;
    waiting_mask_next = waiting_mask;
    status_next       = rlwq_pkg::ST_ERROR;
    woken_valid_next  = 1'b0;
    woken_thread_next = '0;
    fifo_push         = 1'b0;

    if (tid_ok) begin
      if (req.req_type == rlwq_pkg::REQ_ACQUIRE) begin
        if (waiting_mask[tid_idx]) begin
          status_next = rlwq_pkg::ST_ERROR;
        end else if (lock_free) begin
          lock_free_next  = 1'b0;
          holder_id_next  = req.thread_id;
          nest_count_next = rlwq_pkg::COUNT_BITS'(1);
          status_next     = rlwq_pkg::ST_GRANT;
        end else if (holder_id == req.thread_id) begin
          if (nest_count == count_max) begin
            status_next = rlwq_pkg::ST_ERROR;
          end else begin
            nest_count_next = nest_count + 1'b1;
            status_next     = rlwq_pkg::ST_NEST;
          end
        end else if (32'(fifo_fill) >= rlwq_pkg::THREADS) begin
          status_next = rlwq_pkg::ST_ERROR;
        end else begin
          fifo_push                  = 1'b1;
          fifo_tail_next             = next_slot(fifo_tail);
          fifo_fill_next             = fifo_fill + 1'b1;
          waiting_mask_next[tid_idx] = 1'b1;
          status_next                = rlwq_pkg::ST_BLOCKED;
        end
      end else begin
        if (lock_free || holder_id != req.thread_id) begin
          status_next = rlwq_pkg::ST_ERROR;
        end else if (nest_count > rlwq_pkg::COUNT_BITS'(1)) begin
          nest_count_next = nest_count - 1'b1;
          status_next     = rlwq_pkg::ST_NEST_REL;
        end else begin
          lock_free_next  = 1'b1;
          holder_id_next  = '0;
          nest_count_next = '0;
          status_next     = rlwq_pkg::ST_FREED;
          if (fifo_fill != '0) begin
            fifo_head_next                                  = next_slot(fifo_head);
            fifo_fill_next                                  = fifo_fill - 1'b1;
            waiting_mask_next[rlwq_pkg::PtrW'(head_tid)]    = 1'b0;
            woken_valid_next                                = 1'b1;
            woken_thread_next                               = head_tid;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_free    <= 1'b1;
      holder_id    <= '0;
      nest_count   <= '0;
      fifo_head    <= '0;
      fifo_tail    <= '0;
      fifo_fill    <= '0;
      waiting_mask <= '0;
    end else if (acc) begin
      lock_free    <= lock_free_next;
      holder_id    <= holder_id_next;
      nest_count   <= nest_count_next;
      fifo_head    <= fifo_head_next;
      fifo_tail    <= fifo_tail_next;
      fifo_fill    <= fifo_fill_next;
      waiting_mask <= waiting_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && fifo_push) begin
      waiter_fifo[fifo_tail] <= req.thread_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_status       <= status_next;
      out_woken_valid  <= woken_valid_next;
      out_woken_thread <= woken_thread_next;
      out_hold_depth   <= rlwq_pkg::HoldW'(nest_count_next);
    end
  end

  assign res.valid        = out_valid;
  assign res.status       = out_status;
  assign res.woken_valid  = out_woken_valid;
  assign res.woken_thread = out_woken_thread;
  assign res.hold_depth   = out_hold_depth;

  `RLWQ_ASSERT(a_free_zero, lock_free |-> (nest_count == '0), "Free lock has a count")
  `RLWQ_ASSERT(a_held_count, !lock_free |-> (nest_count != '0), "Held lock has no count")
  `RLWQ_ASSERT(a_mask_fill, $countones(waiting_mask) == fifo_fill, "Mask and fill disagree")
  `RLWQ_ASSERT(a_res_follows, $past(acc) |-> out_valid, "Accepted request left no result")
  `RLWQ_ASSERT_ALWAYS(a_no_acc_rst, rst |-> !acc, "Request accepted during reset")

endmodule
